// File: design/qpnt_pkg.sv
// Shared types and constants for the quadratic-probe name table.
// Depends on nothing; imported by qpnt_hash and quadratic_probe_name_table.
`timescale 1ns / 1ps

package qpnt_pkg;

  localparam int unsigned TableSlots = 31;
  localparam int unsigned ProbeLimit = 15;
  localparam int unsigned NameChars  = 7;

  localparam int unsigned CharW   = 16;
  localparam int unsigned ValueW  = 8;
  localparam int unsigned LenInW  = 4;
  localparam int unsigned HashW   = 32;
  localparam int unsigned SlotW   = $clog2(TableSlots);
  localparam int unsigned LenW    = $clog2(NameChars + 1);
  localparam int unsigned ProbeW  = $clog2(ProbeLimit + 1);
  localparam int unsigned NameIdxW = (NameChars > 1) ? $clog2(NameChars) : 1;
  // The hash remainder is worked out two bits per step.
  localparam int unsigned ModSteps = HashW / 2;
  localparam int unsigned ModCntW  = $clog2(ModSteps);
  localparam int unsigned RemW     = SlotW + 2;

  localparam logic [RemW-1:0]  Slots1 = RemW'(TableSlots);
  localparam logic [RemW-1:0]  Slots2 = RemW'(2 * TableSlots);
  localparam logic [RemW-1:0]  Slots3 = RemW'(3 * TableSlots);
  localparam logic [SlotW:0]   SlotsW = (SlotW + 1)'(TableSlots);
  localparam logic [ProbeW-1:0] LastProbe = ProbeW'(ProbeLimit - 1);
  localparam logic [ModCntW-1:0] LastModStep = ModCntW'(ModSteps - 1);

  typedef enum logic [1:0] {
    CmdSet    = 2'd0,
    CmdGet    = 2'd1,
    CmdDelete = 2'd2,
    CmdClear  = 2'd3
  } cmd_e;

  typedef logic [NameChars-1:0][CharW-1:0] name_t;

  typedef struct packed {
    logic            start;
    logic [LenW-1:0] len;
  } hash_req_t;

  typedef struct packed {
    logic             done;
    logic [SlotW-1:0] home;
  } hash_rsp_t;

endpackage

// File: design/qpnt_hash.sv
// Home-slot unit: one shared 32-bit adder sums the shifted characters, then a
// radix-4 restoring remainder step reduces the sum modulo the table size.
// Depends on qpnt_pkg.
`timescale 1ns / 1ps

module qpnt_hash import qpnt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  hash_req_t req_i,
  input  name_t    name_i,
  output hash_rsp_t rsp_o
);

  typedef enum logic [1:0] {
    HIdle,
    HSum,
    HMod,
    HDone
  } hstate_e;

  hstate_e             state_q;
  logic [LenW-1:0]     len_q;
  logic [LenW-1:0]     idx_q;
  logic [ModCntW-1:0]  cnt_q;
  logic [HashW-1:0]    sum_q;
  logic [SlotW-1:0]    rem_q;

  logic [HashW-1:0] term;
  logic [RemW-1:0]  trial;
  logic [RemW-1:0]  rem_next;

  // Character idx shifted left by four bits per position, wrapping at 32 bits.
  assign term = HashW'(HashW'(name_i[idx_q[NameIdxW-1:0]]) << {idx_q, 2'b00});

  assign trial = {rem_q, sum_q[HashW-1 -: 2]};

  always_comb begin
    if (trial >= Slots3) begin
      rem_next = trial - Slots3;
    end else if (trial >= Slots2) begin
      rem_next = trial - Slots2;
    end else if (trial >= Slots1) begin
      rem_next = trial - Slots1;
    end else begin
      rem_next = trial;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= HIdle;
      len_q   <= '0;
      idx_q   <= '0;
      cnt_q   <= '0;
      sum_q   <= '0;
      rem_q   <= '0;
    end else begin
      case (state_q)
        HIdle: begin
          if (req_i.start) begin
            len_q   <= req_i.len;
            idx_q   <= '0;
            sum_q   <= '0;
            state_q <= HSum;
          end
        end
        HSum: begin
          if (idx_q == len_q) begin
            cnt_q   <= '0;
            rem_q   <= '0;
            state_q <= HMod;
          end else begin
            sum_q <= sum_q + term;
            idx_q <= idx_q + LenW'(1);
          end
        end
        HMod: begin
          rem_q <= rem_next[SlotW-1:0];
          sum_q <= sum_q << 2;
          cnt_q <= cnt_q + ModCntW'(1);
          if (cnt_q == LastModStep) begin
            state_q <= HDone;
          end
        end
        HDone: begin
          state_q <= HIdle;
        end
        default: begin
          state_q <= HIdle;
        end
      endcase
    end
  end

  assign rsp_o.done = (state_q == HDone);
  assign rsp_o.home = rem_q;

endmodule

// File: design/quadratic_probe_name_table.sv
// Top level of the quadratic-probe name table: command sequencer, slot store
// and result register. Depends on qpnt_pkg and qpnt_hash.
`timescale 1ns / 1ps

// The block keeps a 31-slot open-addressed table that maps names of up to
// seven 16-bit characters to a byte. One command beat is taken at a time and
// in_ready_o is high only while the sequencer is idle. A clear command, or a
// name that is longer than seven characters, goes from idle straight to the
// result state. Set, get and delete hash the name up to its first zero
// character and then make 1 to 15 probes: the characters are summed through
// one shared adder, the 32-bit sum is reduced modulo 31 two bits at a time,
// and one probe per cycle then visits slot (home + k*k) mod 31, the next slot
// being formed by adding the odd step 2k + 1. The stored characters sit in a
// row-wide memory whose registered read is addressed by the next slot, so
// the comparison of a whole name needs no extra state. The result beat waits
// in its own register; a new command is accepted while it still waits.
module quadratic_probe_name_table import qpnt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        cmd_i,
  input  logic [LenInW-1:0] name_len_i,
  input  logic [CharW-1:0]  name_char_0_i,
  input  logic [CharW-1:0]  name_char_1_i,
  input  logic [CharW-1:0]  name_char_2_i,
  input  logic [CharW-1:0]  name_char_3_i,
  input  logic [CharW-1:0]  name_char_4_i,
  input  logic [CharW-1:0]  name_char_5_i,
  input  logic [CharW-1:0]  name_char_6_i,
  input  logic [ValueW-1:0] set_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              ok_o,
  output logic [ValueW-1:0] found_value_o,
  output logic [SlotW-1:0]  slot_o
);

  typedef enum logic [1:0] {
    SIdle,
    SHash,
    SProbe,
    SResult
  } state_e;

  state_e            state_q;
  cmd_e              cmd_q;
  logic [LenW-1:0]   len_q;
  name_t             name_q;
  logic [ValueW-1:0] value_q;
  logic [SlotW-1:0]  s_q, s_d;
  logic [SlotW-1:0]  incr_q;
  logic [ProbeW-1:0] k_q;
  logic              res_ok_q;
  logic [ValueW-1:0] res_val_q;
  logic [SlotW-1:0]  res_slot_q;
  logic              out_valid_q;
  logic              ok_q;
  logic [ValueW-1:0] val_q;
  logic [SlotW-1:0]  slot_q;

  // Slot store: lengths and values reset to zero; characters are a memory.
  logic [LenW-1:0]   slot_len_q [TableSlots];
  logic [ValueW-1:0] slot_val_q [TableSlots];
  name_t             chars_mem  [TableSlots];
  name_t             chars_rd_q;

  name_t             name_in;
  cmd_e              cmd_in;
  logic [LenW-1:0]   eff_len;
  logic              accept;
  logic              clear_now;
  logic              too_long;
  logic              chars_eq;
  logic              hit;
  logic              set_hit;
  logic              del_hit;
  logic [SlotW:0]    s_sum;
  logic [SlotW-1:0]  s_next;
  logic [SlotW:0]    incr_sum;
  logic [SlotW-1:0]  incr_next;
  logic              out_free;
  hash_req_t         hash_req;
  hash_rsp_t         hash_rsp;

  assign name_in = {name_char_6_i, name_char_5_i, name_char_4_i, name_char_3_i,
                    name_char_2_i, name_char_1_i, name_char_0_i};
  assign cmd_in  = cmd_e'(cmd_i);

  assign in_ready_o = (state_q == SIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign clear_now  = accept && (cmd_in == CmdClear);
  assign too_long   = (name_len_i > LenInW'(NameChars));

  // The name stops at its first zero character, as a C string would.
  always_comb begin
    eff_len = LenW'(NameChars);
    for (int i = NameChars - 1; i >= 0; i--) begin
      if (name_in[i] == '0) begin
        eff_len = LenW'(i);
      end
    end
    if (name_len_i[LenW-1:0] < eff_len) begin
      eff_len = name_len_i[LenW-1:0];
    end
  end

  assign hash_req.start = accept && (cmd_in != CmdClear) && !too_long;
  assign hash_req.len   = eff_len;

  qpnt_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hash_req),
    .name_i (name_q),
    .rsp_o  (hash_rsp)
  );

  // Probe k visits home + k*k; the step from k to k+1 adds 2k+1, both mod 31.
  assign s_sum     = {1'b0, s_q} + {1'b0, incr_q};
  assign s_next    = (s_sum >= SlotsW) ? SlotW'(s_sum - SlotsW) : s_sum[SlotW-1:0];
  assign incr_sum  = {1'b0, incr_q} + (SlotW + 1)'(2);
  assign incr_next = (incr_sum >= SlotsW) ? SlotW'(incr_sum - SlotsW)
                                          : incr_sum[SlotW-1:0];

  // chars_rd_q holds the row of s_q during a probe.
  always_comb begin
    chars_eq = 1'b1;
    for (int i = 0; i < NameChars; i++) begin
      if ((LenW'(i) < len_q) && (chars_rd_q[i] != name_q[i])) begin
        chars_eq = 1'b0;
      end
    end
  end

  always_comb begin
    if (cmd_q == CmdSet) begin
      hit = (slot_len_q[s_q] == '0);
    end else begin
      hit = (slot_len_q[s_q] == len_q) && chars_eq;
    end
  end

  assign set_hit = (state_q == SProbe) && hit && (cmd_q == CmdSet);
  assign del_hit = (state_q == SProbe) && hit && (cmd_q == CmdDelete);

  always_comb begin
    s_d = s_q;
    if ((state_q == SHash) && hash_rsp.done) begin
      s_d = hash_rsp.home;
    end else if ((state_q == SProbe) && !hit && (k_q != LastProbe)) begin
      s_d = s_next;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (set_hit) begin
      for (int i = 0; i < NameChars; i++) begin
        if (LenW'(i) < len_q) begin
          chars_mem[s_q][i] <= name_q[i];
        end
      end
    end
    chars_rd_q <= chars_mem[s_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TableSlots; i++) begin
        slot_len_q[i] <= '0;
        slot_val_q[i] <= '0;
      end
    end else if (clear_now) begin
      for (int i = 0; i < TableSlots; i++) begin
        slot_len_q[i] <= '0;
        slot_val_q[i] <= '0;
      end
    end else if (set_hit) begin
      slot_len_q[s_q] <= len_q;
      slot_val_q[s_q] <= value_q;
    end else if (del_hit) begin
      slot_len_q[s_q] <= '0;
      slot_val_q[s_q] <= '0;
    end
  end

  // Command payload is captured at acceptance and needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_in;
      len_q   <= eff_len;
      name_q  <= name_in;
      value_q <= set_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      s_q         <= '0;
      incr_q      <= '0;
      k_q         <= '0;
      res_ok_q    <= 1'b0;
      res_val_q   <= '0;
      res_slot_q  <= '0;
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      val_q       <= '0;
      slot_q      <= '0;
    end else begin
      s_q <= s_d;
      // In the result state the register is reloaded below instead.
      if (out_valid_q && out_ready_i && (state_q != SResult)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        SIdle: begin
          if (accept) begin
            res_ok_q   <= (cmd_in == CmdClear);
            res_val_q  <= '0;
            res_slot_q <= '0;
            if ((cmd_in == CmdClear) || too_long) begin
              state_q <= SResult;
            end else begin
              state_q <= SHash;
            end
          end
        end
        SHash: begin
          if (hash_rsp.done) begin
            k_q     <= '0;
            incr_q  <= SlotW'(1);
            state_q <= SProbe;
          end
        end
        SProbe: begin
          if (hit) begin
            res_ok_q   <= 1'b1;
            res_slot_q <= s_q;
            res_val_q  <= (cmd_q == CmdGet) ? slot_val_q[s_q] : '0;
            state_q    <= SResult;
          end else if (k_q == LastProbe) begin
            state_q <= SResult;
          end else begin
            k_q    <= k_q + ProbeW'(1);
            incr_q <= incr_next;
          end
        end
        SResult: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            ok_q        <= res_ok_q;
            val_q       <= res_val_q;
            slot_q      <= res_slot_q;
            state_q     <= SIdle;
          end
        end
        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = ok_q;
  assign found_value_o = val_q;
  assign slot_o        = slot_q;

  // The probe walk stays inside the table and within the probe limit.
  a_probe_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SProbe) |-> (s_q < SlotW'(TableSlots)) && (k_q <= LastProbe))
    else $error("probe slot or probe count out of range");

  // A failed command reports neither a value nor a slot.
  a_fail_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !ok_q) |-> (val_q == '0) && (slot_q == '0))
    else $error("failed command reports a value or slot");

  // The hash unit only finishes while the sequencer waits for it.
  a_hash_done_in_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_rsp.done |-> (state_q == SHash))
    else $error("hash result arrived outside the hash phase");

  // A clear empties the table on the next cycle; checked on slot 0 and the result state.
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_now |=> (slot_len_q[0] == '0) && (state_q == SResult))
    else $error("clear did not empty the table");

endmodule
